// ----- rtl/tpf_pkg.sv -----
// Shared types and constants for the three-axis trapezoid profile feasibility block.
package tpf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int WORD_W        = 32;
	localparam int WIDE_W        = 64;
	localparam int NEG_W         = 66;
	localparam int RAD_W         = 128;
	localparam int ROOT_W        = 64;
	localparam int REM_W         = 68;
	localparam int SQRT_STAGES   = ROOT_W;
	// six front stages, the root stages, one output stage
	localparam int AXIS_LAT      = 6 + SQRT_STAGES + 1;
	localparam int CFG_IDX_W     = 2;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL_Z = 2'd2;

	localparam logic [WORD_W-1:0] MAX_ACCEL_RST = 32'd131072;

	typedef struct packed {
		logic signed [31:0] disp_x;
		logic signed [31:0] disp_y;
		logic signed [31:0] disp_z;
		logic signed [31:0] start_vel_x;
		logic signed [31:0] start_vel_y;
		logic signed [31:0] start_vel_z;
		logic        [31:0] duration;
	} tpf_req_t;

	typedef struct packed {
		logic               feasible;
		logic signed [31:0] cruise_x;
		logic signed [31:0] cruise_y;
		logic signed [31:0] cruise_z;
	} tpf_res_t;

	typedef struct packed {
		logic                      ok;
		logic signed [WORD_W-1:0]  vel;
	} tpf_axis_res_t;

endpackage

// ----- rtl/tpf_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with sideband delay.
module tpf_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic                       clk,
	input  logic [tpf_pkg::RAD_W-1:0]  rad,
	input  logic [SIDE_W-1:0]          side_in,
	output logic [tpf_pkg::ROOT_W-1:0] root,
	output logic [SIDE_W-1:0]          side_out
);
	import tpf_pkg::*;

	logic [RAD_W-1:0]  rad_s  [SQRT_STAGES];
	logic [REM_W-1:0]  rem_s  [SQRT_STAGES];
	logic [ROOT_W-1:0] root_s [SQRT_STAGES];
	logic [SIDE_W-1:0] side_s [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic [RAD_W-1:0]  rad_prev;
		logic [REM_W-1:0]  rem_prev;
		logic [ROOT_W-1:0] root_prev;
		logic [SIDE_W-1:0] side_prev;
		logic [REM_W-1:0]  rem_sh;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rad_prev  = rad;
			assign rem_prev  = '0;
			assign root_prev = '0;
			assign side_prev = side_in;
		end else begin : g_next
			assign rad_prev  = rad_s[k-1];
			assign rem_prev  = rem_s[k-1];
			assign root_prev = root_s[k-1];
			assign side_prev = side_s[k-1];
		end

		// bring down the next two radicand bits, try root*4+1
		assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[RAD_W-1 -: 2]};
		assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_prev, 2'b01};
		assign ge     = (rem_sh >= trial);

		always_ff @(posedge clk) begin
			rad_s[k]  <= {rad_prev[RAD_W-3:0], 2'b00};
			rem_s[k]  <= ge ? (rem_sh - trial) : rem_sh;
			root_s[k] <= {root_prev[ROOT_W-2:0], ge};
			side_s[k] <= side_prev;
		end
	end

	assign root     = root_s[SQRT_STAGES-1];
	assign side_out = side_s[SQRT_STAGES-1];

endmodule

// ----- rtl/tpf_axis.sv -----
// One axis: profile discriminant, square root and cruise velocity.
module tpf_axis #(
	parameter int FRAC_BITS = tpf_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic signed [31:0]          disp,
	input  logic signed [31:0]          start_vel,
	input  logic        [31:0]          duration,
	input  logic        [31:0]          max_accel,
	output tpf_pkg::tpf_axis_res_t      res
);
	import tpf_pkg::*;

	localparam int SIDE_W = WIDE_W + 2;

	// stage 1: magnitudes and signs
	logic [WORD_W-1:0] h_mag_s1, v_mag_s1, t_s1, a_s1;
	logic              hneg_s1, opp_s1;
	// stage 2: products
	logic [WIDE_W-1:0] at_full_s2, vv_s2, ah_s2;
	logic [WORD_W-1:0] v_mag_s2;
	logic              hneg_s2, opp_s2;
	// stage 3: w and subtrahend
	logic [WIDE_W-1:0] w_s3;
	logic [NEG_W-1:0]  neg_s3;
	logic              hneg_s3, fail_s3;
	// stage 4: partial products of w*w
	logic [WIDE_W-1:0] p00_s4, p01_s4, p10_s4, p11_s4;
	logic [WIDE_W-1:0] w_s4;
	logic [NEG_W-1:0]  neg_s4;
	logic              hneg_s4, fail_s4;
	// stage 5: w squared
	logic [RAD_W-1:0]  sq_s5;
	logic [WIDE_W-1:0] w_s5;
	logic [NEG_W-1:0]  neg_s5;
	logic              hneg_s5, fail_s5;
	// stage 6: discriminant
	logic [RAD_W-1:0]  disc_s6;
	logic [WIDE_W-1:0] w_s6;
	logic              hneg_s6, fail_s6;

	logic              hneg_in, vneg_in;
	logic [WORD_W-1:0] h_mag_in, v_mag_in;
	logic [WIDE_W-1:0] at_s2;
	logic [WIDE_W-1:0] v_sh_s2;
	logic [RAD_W:0]    diff_s5;
	logic [ROOT_W-1:0] root;
	logic [SIDE_W-1:0] side_out;
	logic [WIDE_W-1:0] w_q;
	logic              hneg_q, fail_q;
	logic [WIDE_W-1:0] m_full;
	logic [WORD_W-1:0] m_sat;
	tpf_axis_res_t     res_q;

	assign hneg_in  = disp[31];
	assign vneg_in  = start_vel[31];
	assign h_mag_in = hneg_in ? (~disp + 32'd1) : disp;
	assign v_mag_in = vneg_in ? (~start_vel + 32'd1) : start_vel;

	always_ff @(posedge clk) begin
		h_mag_s1 <= h_mag_in;
		v_mag_s1 <= v_mag_in;
		t_s1     <= duration;
		a_s1     <= max_accel;
		hneg_s1  <= hneg_in;
		opp_s1   <= (h_mag_in != '0) && (v_mag_in != '0) && (hneg_in != vneg_in);
	end

	always_ff @(posedge clk) begin
		at_full_s2 <= a_s1 * t_s1;
		vv_s2      <= v_mag_s1 * v_mag_s1;
		ah_s2      <= a_s1 * h_mag_s1;
		v_mag_s2   <= v_mag_s1;
		hneg_s2    <= hneg_s1;
		opp_s2     <= opp_s1;
	end

	assign at_s2   = at_full_s2 >> FRAC_BITS;
	assign v_sh_s2 = {{(WIDE_W-WORD_W){1'b0}}, v_mag_s2} << FRAC_BITS;

	always_ff @(posedge clk) begin
		w_s3    <= opp_s2 ? (at_s2 - {{(WIDE_W-WORD_W){1'b0}}, v_mag_s2})
		                  : (at_s2 + {{(WIDE_W-WORD_W){1'b0}}, v_mag_s2});
		neg_s3  <= ({2'b00, vv_s2} << 1) + ({2'b00, ah_s2} << 2);
		fail_s3 <= opp_s2 && (v_sh_s2 >= at_full_s2);
		hneg_s3 <= hneg_s2;
	end

	always_ff @(posedge clk) begin
		p00_s4  <= w_s3[31:0]  * w_s3[31:0];
		p01_s4  <= w_s3[31:0]  * w_s3[63:32];
		p10_s4  <= w_s3[63:32] * w_s3[31:0];
		p11_s4  <= w_s3[63:32] * w_s3[63:32];
		w_s4    <= w_s3;
		neg_s4  <= neg_s3;
		fail_s4 <= fail_s3;
		hneg_s4 <= hneg_s3;
	end

	always_ff @(posedge clk) begin
		sq_s5   <= {64'd0, p00_s4} + {32'd0, p01_s4, 32'd0} + {32'd0, p10_s4, 32'd0}
		         + {p11_s4, 64'd0};
		w_s5    <= w_s4;
		neg_s5  <= neg_s4;
		fail_s5 <= fail_s4;
		hneg_s5 <= hneg_s4;
	end

	assign diff_s5 = {1'b0, sq_s5} - {{(RAD_W+1-NEG_W){1'b0}}, neg_s5};

	always_ff @(posedge clk) begin
		disc_s6 <= diff_s5[RAD_W-1:0];
		fail_s6 <= fail_s5 | diff_s5[RAD_W] | (diff_s5[RAD_W-1:0] == '0);
		w_s6    <= w_s5;
		hneg_s6 <= hneg_s5;
	end

	tpf_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
		.clk      (clk),
		.rad      (disc_s6),
		.side_in  ({hneg_s6, fail_s6, w_s6}),
		.root     (root),
		.side_out (side_out)
	);

	assign hneg_q = side_out[SIDE_W-1];
	assign fail_q = side_out[SIDE_W-2];
	assign w_q    = side_out[WIDE_W-1:0];

	assign m_full = (w_q - root) >> 1;
	assign m_sat  = (m_full > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : m_full[WORD_W-1:0];

	always_ff @(posedge clk) begin
		res_q.ok  <= ~fail_q;
		res_q.vel <= hneg_q ? (~m_sat + 32'd1) : m_sat;
	end

	assign res = res_q;

endmodule

// ----- rtl/trapezoid_profile_feasibility_3axis.sv -----
// Top level of the three-axis trapezoid profile feasibility pipeline.
//
// Takes one request transaction per clock (start high; busy is always low) and
// returns one result transaction per request, in order, marked by a one-cycle
// done strobe. Each request passes six stages of products and discriminant,
// then the 64-stage square-root pipeline, one root bit per stage, then the
// axis output and result registers. Results cannot be held off: the
// receiver must take done/res in the cycle they appear. Throughput is one
// transaction per cycle. Acceleration limits are to be written through cfg_we /
// cfg_idx / cfg_data while no request is in flight, which the user must ensure; index 3 is ignored.
module trapezoid_profile_feasibility_3axis #(
	parameter int FRAC_BITS = tpf_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  tpf_pkg::tpf_req_t             req,
	output logic                          done,
	output tpf_pkg::tpf_res_t             res,
	input  logic                          cfg_we,
	input  logic [tpf_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]                   cfg_data
);
	import tpf_pkg::*;

	logic [WORD_W-1:0]   accel_x_q, accel_y_q, accel_z_q;
	logic [AXIS_LAT-1:0] vld_q;
	logic                accept;
	logic                all_ok;
	tpf_axis_res_t       ax_x, ax_y, ax_z;
	tpf_res_t            res_q;
	logic                done_q;

	// never stalls: every cycle can take a new transaction
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_x_q <= MAX_ACCEL_RST;
			accel_y_q <= MAX_ACCEL_RST;
			accel_z_q <= MAX_ACCEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_ACCEL_X: accel_x_q <= cfg_data;
				REG_MAX_ACCEL_Y: accel_y_q <= cfg_data;
				REG_MAX_ACCEL_Z: accel_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// valid bits ride alongside the axis pipelines
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[AXIS_LAT-2:0], accept};
		end
	end

	tpf_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
		.clk       (clk),
		.disp      (req.disp_x),
		.start_vel (req.start_vel_x),
		.duration  (req.duration),
		.max_accel (accel_x_q),
		.res       (ax_x)
	);

	tpf_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
		.clk       (clk),
		.disp      (req.disp_y),
		.start_vel (req.start_vel_y),
		.duration  (req.duration),
		.max_accel (accel_y_q),
		.res       (ax_y)
	);

	tpf_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
		.clk       (clk),
		.disp      (req.disp_z),
		.start_vel (req.start_vel_z),
		.duration  (req.duration),
		.max_accel (accel_z_q),
		.res       (ax_z)
	);

	// any failing axis zeroes all three velocities
	assign all_ok = ax_x.ok & ax_y.ok & ax_z.ok;

	always_ff @(posedge clk) begin
		res_q.feasible <= all_ok;
		res_q.cruise_x <= all_ok ? ax_x.vel : '0;
		res_q.cruise_y <= all_ok ? ax_y.vel : '0;
		res_q.cruise_z <= all_ok ? ax_z.vel : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[AXIS_LAT-1];
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the three-axis trapezoid profile feasibility block.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import tpf_pkg::*;

	// Expected results in flight, oldest first, plus the mismatch count.
	class feasibility_scoreboard;
		tpf_res_t pending[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note_request(tpf_res_t exp_res);
			pending.push_back(exp_res);
		endfunction

		task check_result(tpf_res_t got);
			tpf_res_t exp_res;
			if (pending.size() == 0) begin
				report_mismatch("result with no request outstanding");
				return;
			end
			exp_res = pending.pop_front();
			if (got.feasible !== exp_res.feasible)
				report_mismatch($sformatf("feasible got %b exp %b",
					got.feasible, exp_res.feasible));
			if (got.cruise_x !== exp_res.cruise_x)
				report_mismatch($sformatf("cruise_x got %h exp %h",
					got.cruise_x, exp_res.cruise_x));
			if (got.cruise_y !== exp_res.cruise_y)
				report_mismatch($sformatf("cruise_y got %h exp %h",
					got.cruise_y, exp_res.cruise_y));
			if (got.cruise_z !== exp_res.cruise_z)
				report_mismatch($sformatf("cruise_z got %h exp %h",
					got.cruise_z, exp_res.cruise_z));
		endtask

		task report_mismatch(string msg);
			errors++;
			$display("tb: mismatch at %0t: %s", $realtime, msg);
		endtask
	endclass

	localparam int FB        = FRAC_BITS_DEF;
	localparam int LATENCY   = AXIS_LAT + 1;
	localparam int MAX_CYCLES = 400000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	tpf_req_t    req;
	logic        done;
	tpf_res_t    res;
	logic        cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [31:0] cfg_data;

	feasibility_scoreboard sb;
	logic [31:0] accel_lim [3];
	int          idle_pct;
	int          cycles;

	trapezoid_profile_feasibility_3axis dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .res(res), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Watchdog: generous against 698 requests, one phase at 66% idling, plus pipeline drains.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= MAX_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Results cannot be stalled; check every strobed transaction.
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(res);
	end

	// Exact integer floor square root of a 128-bit value.
	function automatic logic [63:0] floor_root(logic [127:0] d);
		logic [63:0]  r;
		logic [63:0]  c;
		logic [127:0] c2;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			c2 = 128'(c) * 128'(c);
			if (c2 <= d)
				r = c;
		end
		return r;
	endfunction

	// One axis: returns ok and writes the cruise velocity pattern.
	function automatic logic axis_cruise(logic [31:0] h, logic [31:0] v0,
		logic [31:0] dur, logic [31:0] acc, output logic [31:0] vel);
		logic         hneg;
		logic         vneg;
		logic [63:0]  hmag;
		logic [63:0]  vmag;
		logic [63:0]  a_t;
		logic [63:0]  at;
		logic [63:0]  w;
		logic [63:0]  s;
		logic [63:0]  m;
		logic [127:0] sq;
		logic [127:0] neg;
		hneg = h[31];
		vneg = v0[31];
		hmag = 64'(hneg ? 32'(-h) : h);
		vmag = 64'(vneg ? 32'(-v0) : v0);
		a_t = 64'(acc) * 64'(dur);
		at = a_t >> FB;
		vel = '0;
		if (hmag != 0 && vmag != 0 && hneg != vneg) begin
			// decelerating first: must stop before the move time runs out
			if ((vmag << FB) >= a_t)
				return 1'b0;
			w = at - vmag;
		end else begin
			w = at + vmag;
		end
		sq = 128'(w) * 128'(w);
		neg = 128'(64'(vmag * vmag * 64'd2)) + 128'(64'(acc) * 64'd4) * 128'(hmag);
		if (sq <= neg)
			return 1'b0;
		s = floor_root(sq - neg);
		m = (w - s) >> 1;
		if (m > 64'h7FFF_FFFF)
			m = 64'h7FFF_FFFF;
		vel = hneg ? 32'(-m) : m[31:0];
		return 1'b1;
	endfunction

	function automatic tpf_res_t predict_cruise(tpf_req_t r);
		tpf_res_t    o;
		logic [31:0] vx;
		logic [31:0] vy;
		logic [31:0] vz;
		logic        ok;
		ok = axis_cruise(r.disp_x, r.start_vel_x, r.duration,
			accel_lim[REG_MAX_ACCEL_X], vx);
		ok = axis_cruise(r.disp_y, r.start_vel_y, r.duration,
			accel_lim[REG_MAX_ACCEL_Y], vy) && ok;
		ok = axis_cruise(r.disp_z, r.start_vel_z, r.duration,
			accel_lim[REG_MAX_ACCEL_Z], vz) && ok;
		o.feasible = ok;
		o.cruise_x = ok ? vx : '0;
		o.cruise_y = ok ? vy : '0;
		o.cruise_z = ok ? vz : '0;
		return o;
	endfunction

	// Wait out every outstanding result, then at least the pipeline depth again.
	task drain_pipe();
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// One write, then cfg_we is dropped again before the next.
	task write_accel(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		if (idx <= REG_MAX_ACCEL_Z)
			accel_lim[idx] = val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task set_accels(logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
		drain_pipe();
		write_accel(REG_MAX_ACCEL_X, ax);
		write_accel(REG_MAX_ACCEL_Y, ay);
		write_accel(REG_MAX_ACCEL_Z, az);
	endtask

	// Present one request; start stays high across back-to-back transactions.
	task send_request(tpf_req_t r);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sb.note_request(predict_cruise(r));
	endtask

	task finish_burst();
		start <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(65536 * 64)) - 65536 * 32);
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			3: return 32'h8000_0000 | $urandom_range(3);
			default: return 32'($signed($urandom_range(65536 * 8)) - 65536 * 4);
		endcase
	endfunction

	// Random moves: full-range, small, sign-extended and near-minimum words, with occasional zero start_vel_y or disp_z.
	function automatic tpf_req_t rand_request();
		tpf_req_t r;
		r.duration = ($urandom_range(3) == 0) ? $urandom : $urandom_range(65536 * 16);
		r.disp_x = rand_word();
		r.disp_y = rand_word();
		r.disp_z = rand_word();
		r.start_vel_x = rand_word();
		r.start_vel_y = rand_word();
		r.start_vel_z = rand_word();
		if ($urandom_range(9) == 0)
			r.start_vel_y = '0;
		if ($urandom_range(9) == 0)
			r.disp_z = '0;
		return r;
	endfunction

	function automatic tpf_req_t mk_req(logic [31:0] h, logic [31:0] v, logic [31:0] t);
		tpf_req_t r;
		r.disp_x = h;
		r.disp_y = h;
		r.disp_z = h;
		r.start_vel_x = v;
		r.start_vel_y = v;
		r.start_vel_z = v;
		r.duration = t;
		return r;
	endfunction

	task random_phase(int n, int pct);
		idle_pct = pct;
		for (int i = 0; i < n; i++)
			send_request(rand_request());
		finish_burst();
	endtask

	initial begin
		sb = new();
		cycles = 0;
		idle_pct = 0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		for (int i = 0; i < 3; i++)
			accel_lim[i] = MAX_ACCEL_RST;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset limits, sign cases, zero fields, extremes.
		send_request(mk_req(32'h0001_0000, 32'h0000_8000, 32'h0004_0000));
		send_request(mk_req(32'hFFFF_0000, 32'hFFFF_8000, 32'h0004_0000));
		send_request(mk_req(32'h0001_0000, 32'hFFFF_8000, 32'h0004_0000));
		send_request(mk_req(32'hFFFF_0000, 32'h0000_8000, 32'h0004_0000));
		send_request(mk_req(32'h0001_0000, 32'hFFF0_0000, 32'h0001_0000));
		send_request(mk_req(32'h0000_0000, 32'h0001_0000, 32'h0002_0000));
		send_request(mk_req(32'h0002_0000, 32'h0000_0000, 32'h0002_0000));
		send_request(mk_req(32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
		send_request(mk_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		send_request(mk_req(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF));
		send_request(mk_req(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
		send_request(mk_req(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF));
		send_request(mk_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001));
		finish_burst();
		// zero acceleration: always infeasible
		set_accels(32'd0, 32'd0, 32'd0);
		send_request(mk_req(32'h0001_0000, 32'h0000_8000, 32'h0004_0000));
		send_request(mk_req(32'h0001_0000, 32'hFFFF_8000, 32'h0004_0000));
		finish_burst();
		// largest limits: saturation of the cruise magnitude
		set_accels(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(mk_req(32'h0000_0001, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
		send_request(mk_req(32'hFFFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF));
		send_request(mk_req(32'h7FFF_FFFF, 32'h0001_0000, 32'h0010_0000));
		finish_burst();
		// unused register index must not disturb the limits
		drain_pipe();
		write_accel(2'd3, 32'h1234_5678);

		// Random phases across several limit settings and idling mixes.
		set_accels(32'd1, 32'h0001_0000, 32'h0010_0000);
		random_phase(170, 0);
		set_accels($urandom, $urandom_range(65536 * 8), $urandom_range(65536 * 2, 1));
		random_phase(170, 66);
		set_accels(MAX_ACCEL_RST, MAX_ACCEL_RST, MAX_ACCEL_RST);
		random_phase(170, 7);
		set_accels(32'hFFFF_FFFF, $urandom_range(65536 * 4, 1), 32'd1);
		random_phase(170, 0);

		drain_pipe();
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ----- trapezoid_profile_feasibility_3axis.f -----
rtl/tpf_pkg.sv
rtl/tpf_sqrt.sv
rtl/tpf_axis.sv
rtl/trapezoid_profile_feasibility_3axis.sv
sim/testbench.sv
